// ===== design/md5_digest_crlf_canonical_unit_assert.svh =====
// Assertion macros for the MD5 line-ending canonical digest unit.
// Depends on nothing; included by the top level.
`ifndef MD5_DIGEST_CRLF_CANONICAL_UNIT_ASSERT_SVH
`define MD5_DIGEST_CRLF_CANONICAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MDC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define MDC_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define MDC_ASSERT_IMP(label, clk, rst, a, c)
`define MDC_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/mdc_pkg.sv =====
// Package for the MD5 canonical digest unit: types, constants and round tables.
// Depends on nothing.
`timescale 1ns / 1ps
package mdc_pkg;
   typedef enum logic [2:0] {
      ST_IDLE, ST_ABSORB, ST_ROUND, ST_FOLD, ST_EMIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic       write_byte;
      logic [7:0] byte_val;
      logic       count_up;
      logic       start_block;
      logic       round_step;
      logic       fold;
      logic       reinit;
      logic       latch_length;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [5:0] fill_pos;
      logic [5:0] round_idx;
   } status_type;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r;
      case ({i[5:4], i[1:0]})
         4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
         4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
         4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
         4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15;
         default: r = 5'd21;
      endcase
      return r;
   endfunction

   // Message word index for round i.
   function automatic logic [3:0] word_sel(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(({i[3:0], 2'b00} + i[3:0]) + 4'd1);
         2'd2: g = 4'(({i[3:0], 1'b0} + i[3:0]) + 4'd5);
         default: g = 4'(({i[3:0], 3'b000} - i[3:0]));
      endcase
      return g;
   endfunction
endpackage

// ===== design/mdc_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on nothing.
`timescale 1ns / 1ps
interface mdc_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       end_of_message;
   modport source (output valid, has_byte, data_byte, end_of_message, input ready);
   modport sink (input valid, has_byte, data_byte, end_of_message, output ready);
endinterface

interface mdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/md5_digest_crlf_canonical_unit.sv =====
// Top level of the MD5 digest unit with CR/LF canonicalization.
// Depends on mdc_pkg, mdc_if, mdc_ctrl, mdc_datapath and the assertion header.
//
//  channel | dir | payload
//  req     | in  | has_byte, data_byte, end_of_message
//  rsp     | out | digest_word, word_index, last_word
//
// A word is accepted in idle, each canonical byte is then written in turn, and the unit returns to idle.
// A full 64-byte block then runs all 64 rounds and a fold step on the single round unit.
// End of message latches the length, then writes up to 72 pad bytes and runs up to two blocks of rounds.
// Synchronous reset restores the MD5 initial chaining words and clears the counter.
// Response stalls hold the digest word; no new word is taken until all four are sent.
`timescale 1ns / 1ps
`include "md5_digest_crlf_canonical_unit_assert.svh"
module md5_digest_crlf_canonical_unit (
   input logic clock,
   input logic reset,
   mdc_req_if.sink   req,
   mdc_rsp_if.source rsp
);
   mdc_pkg::cmd_type    cmd;
   mdc_pkg::status_type status;
   logic [63:0]  length_bits;
   logic [127:0] chain;
   logic [1:0]   widx;
   logic         req_fire, rsp_fire;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   mdc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .has_byte(req.has_byte), .data_byte(req.data_byte),
      .end_of_message(req.end_of_message), .rsp_fire(rsp_fire),
      .status(status), .length_bits(length_bits), .cmd(cmd),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .word_idx(widx)
   );

   mdc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .length_bits(length_bits), .chain(chain)
   );

   assign rsp.digest_word = chain[32 * widx +: 32];
   assign rsp.word_index = widx;
   assign rsp.last_word = (widx == 2'd3);

   `MDC_ASSERT_IMP(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   `MDC_ASSERT_NXT(a_word_step, clock, reset, rsp_fire && !rsp.last_word, rsp.valid)
   `MDC_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, !(cmd.round_step && cmd.write_byte))
endmodule

// ===== design/mdc_datapath.sv =====
// MD5 datapath: block buffer memory, bit counter, chaining words, one round per cycle.
// Depends on mdc_pkg.
`timescale 1ns / 1ps
module mdc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  mdc_pkg::cmd_type   cmd,
   output mdc_pkg::status_type status,
   output logic [63:0]        length_bits,
   output logic [127:0]       chain
);
   logic [31:0] blk_mem [16];
   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff;
   logic [31:0] ha_ff, hb_ff, hc_ff, hd_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] m_word, f_val, sum, rot, b_new;
   logic [5:0]  pos;
   logic [4:0]  sh;

   assign pos = count_ff[8:3];
   assign status.fill_pos = pos;
   assign status.round_idx = rnd_ff;
   assign length_bits = len_ff;
   assign chain = {hd_ff, hc_ff, hb_ff, ha_ff};

   // Bytes land little-endian within each 32-bit word.
   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         blk_mem[pos[5:2]][8 * pos[1:0] +: 8] <= cmd.byte_val;
      end
   end

   assign m_word = blk_mem[mdc_pkg::word_sel(rnd_ff)];

   always_comb begin
      case (rnd_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f_val + mdc_pkg::round_k(rnd_ff) + m_word;
      sh = mdc_pkg::rot_amount(rnd_ff);
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
      b_new = b_ff + rot;
      count_in = cmd.count_up ? count_ff + 64'd8 : count_ff;
      rnd_in = cmd.start_block ? 6'd0 : (cmd.round_step ? rnd_ff + 6'd1 : rnd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         count_ff <= '0;
         rnd_ff <= '0;
         ha_ff <= mdc_pkg::INIT_A;
         hb_ff <= mdc_pkg::INIT_B;
         hc_ff <= mdc_pkg::INIT_C;
         hd_ff <= mdc_pkg::INIT_D;
      end else begin
         count_ff <= count_in;
         rnd_ff <= rnd_in;
         if (cmd.fold) begin
            ha_ff <= ha_ff + a_ff;
            hb_ff <= hb_ff + b_ff;
            hc_ff <= hc_ff + c_ff;
            hd_ff <= hd_ff + d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_length) begin
         len_ff <= count_ff;
      end
      if (cmd.start_block) begin
         a_ff <= ha_ff;
         b_ff <= hb_ff;
         c_ff <= hc_ff;
         d_ff <= hd_ff;
      end else if (cmd.round_step) begin
         a_ff <= d_ff;
         b_ff <= b_new;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end
endmodule

// ===== design/mdc_ctrl.sv =====
// Controller: canonicalizes line endings, sequences padding, rounds and digest output.
// Depends on mdc_pkg.
`timescale 1ns / 1ps
module mdc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                has_byte,
   input  logic [7:0]          data_byte,
   input  logic                end_of_message,
   input  logic                rsp_fire,
   input  mdc_pkg::status_type status,
   input  logic [63:0]         length_bits,
   output mdc_pkg::cmd_type    cmd,
   output logic                req_ready,
   output logic                rsp_valid,
   output logic [1:0]          word_idx
);
   mdc_pkg::state_type state_ff, state_in;
   // Pending canonical bytes: up to two.
   logic [7:0] b0_ff, b0_in, b1_ff, b1_in;
   logic [1:0] npend_ff, npend_in;
   logic       eom_ff, eom_in;
   logic       pad_ff, pad_in;      // padding in progress
   logic       padstart_ff, padstart_in;
   logic       lenok_ff, lenok_in;  // the current block takes the length
   logic       cr_ff, cr_in;
   logic [1:0] widx_ff, widx_in;
   logic [7:0] pad_byte;
   logic [2:0] lsel;

   assign word_idx = widx_ff;
   assign lsel = status.fill_pos[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdc_pkg::ST_IDLE;
         npend_ff <= '0;
         eom_ff <= 1'b0;
         pad_ff <= 1'b0;
         padstart_ff <= 1'b0;
         lenok_ff <= 1'b0;
         cr_ff <= 1'b0;
         widx_ff <= '0;
      end else begin
         state_ff <= state_in;
         npend_ff <= npend_in;
         eom_ff <= eom_in;
         pad_ff <= pad_in;
         padstart_ff <= padstart_in;
         lenok_ff <= lenok_in;
         cr_ff <= cr_in;
         widx_ff <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in;
      b1_ff <= b1_in;
   end

   always_comb begin
      state_in = state_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      npend_in = npend_ff;
      eom_in = eom_ff;
      pad_in = pad_ff;
      padstart_in = padstart_ff;
      lenok_in = lenok_ff;
      cr_in = cr_ff;
      widx_in = widx_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      pad_byte = 8'h00;
      if (padstart_ff) begin
         pad_byte = mdc_pkg::PAD_BYTE;
      end else if (lenok_ff && status.fill_pos >= mdc_pkg::LEN_POS) begin
         pad_byte = length_bits[8 * lsel +: 8];
      end
      case (state_ff)
         mdc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               eom_in = end_of_message;
               npend_in = 2'd0;
               if (has_byte) begin
                  if (data_byte == mdc_pkg::CHAR_CR) begin
                     b0_in = mdc_pkg::CHAR_CR; b1_in = mdc_pkg::CHAR_LF;
                     npend_in = 2'd2; cr_in = 1'b1;
                  end else if (data_byte == mdc_pkg::CHAR_LF) begin
                     if (!cr_ff) begin
                        b0_in = mdc_pkg::CHAR_CR; b1_in = mdc_pkg::CHAR_LF;
                        npend_in = 2'd2;
                     end
                     cr_in = 1'b0;
                  end else begin
                     b0_in = data_byte; npend_in = 2'd1; cr_in = 1'b0;
                  end
               end
               state_in = mdc_pkg::ST_ABSORB;
            end
         end
         mdc_pkg::ST_ABSORB: begin
            if (npend_ff != 2'd0) begin
               cmd.write_byte = 1'b1;
               cmd.byte_val = b0_ff;
               cmd.count_up = 1'b1;
               b0_in = b1_ff;
               npend_in = npend_ff - 2'd1;
            end else if (pad_ff) begin
               cmd.write_byte = 1'b1;
               cmd.byte_val = pad_byte;
               cmd.count_up = 1'b1;
               padstart_in = 1'b0;
            end else if (eom_ff) begin
               // Begin padding: remember the message length first. If the pad mark
               // lands at or past the length slot, the length goes into the next block.
               cmd.latch_length = 1'b1;
               pad_in = 1'b1;
               padstart_in = 1'b1;
               lenok_in = (status.fill_pos < mdc_pkg::LEN_POS);
            end else begin
               state_in = mdc_pkg::ST_IDLE;
            end
            if (cmd.write_byte && status.fill_pos == 6'd63) begin
               cmd.start_block = 1'b1;
               state_in = mdc_pkg::ST_ROUND;
            end
         end
         mdc_pkg::ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_idx == 6'd63) begin
               state_in = mdc_pkg::ST_FOLD;
            end
         end
         mdc_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            // Only the block that carried the length ends the message.
            if (pad_ff && lenok_ff) begin
               state_in = mdc_pkg::ST_EMIT;
            end else begin
               if (pad_ff) begin
                  lenok_in = 1'b1;
               end
               state_in = mdc_pkg::ST_ABSORB;
            end
         end
         mdc_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_fire) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  cmd.reinit = 1'b1;
                  pad_in = 1'b0;
                  lenok_in = 1'b0;
                  eom_in = 1'b0;
                  cr_in = 1'b0;
                  state_in = mdc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mdc_pkg::ST_IDLE;
      endcase
   end
endmodule
